### src/signed_command_pwm_generator_defines.svh
// Assertion macros shared by the PWM generator modules.
`ifndef SIGNED_COMMAND_PWM_GENERATOR_DEFINES_SVH
`define SIGNED_COMMAND_PWM_GENERATOR_DEFINES_SVH
`ifndef SYNTH
`define SCPG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SCPG_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SCPG_ASSERT(name, prop, msg)
`define SCPG_ASSERT_RST(name, prop, msg)
`endif
`endif

### src/scpg_pkg.sv
// Types and constants of the signed command PWM generator.
package scpg_pkg;

  localparam int unsigned CMD_BITS      = 16;
  localparam int unsigned CMP_BITS      = 16;
  localparam int unsigned PERIOD_BITS   = 16;
  localparam int unsigned CFG_IDX_BITS  = 8;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam int unsigned MAG_BITS    = 14;
  localparam int unsigned PROD_BITS   = PERIOD_BITS + MAG_BITS;
  localparam int unsigned QIN_BITS    = PROD_BITS - 11;
  localparam int unsigned RECIP_BITS  = 22;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned QPROD_BITS  = QIN_BITS + RECIP_BITS;
  localparam int unsigned QUO_BITS    = QPROD_BITS - RECIP_SHIFT;

  // command limit of ten units at 1024 per unit
  localparam logic [MAG_BITS-1:0]   CMD_LIMIT = 14'd10240;
  // ceil(2^24 / 5): exact quotient by five for inputs below 2^22
  localparam logic [RECIP_BITS-1:0] RECIP5    = 22'd3355444;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd1500;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PERIOD    = 8'd0,
    REG_DUAL_MODE = 8'd1
  } scpg_reg_e;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SINGLE_A,
    OP_DUAL_A,
    OP_DUAL_B
  } scpg_op_e;

  typedef struct packed {
    logic                       kind;
    logic signed [CMD_BITS-1:0] command;
  } scpg_in_t;

  typedef struct packed {
    logic                pin_a;
    logic                pin_b;
    logic [CMP_BITS-1:0] count_now;
  } scpg_out_t;

  typedef struct packed {
    scpg_op_e            op;
    logic [CMP_BITS-1:0] cmp;
  } scpg_entry_t;

endpackage

### src/scpg_front.sv
// Front end: accepts items, computes compare values, classifies operations.
`include "signed_command_pwm_generator_defines.svh"
module scpg_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [scpg_pkg::PERIOD_BITS-1:0]     period_i,
  input  logic                                 dual_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  scpg_pkg::scpg_in_t                   in_item_i,
  input  logic                                 q_full_i,
  output logic                                 push_o,
  output scpg_pkg::scpg_entry_t                entry_o
);
  import scpg_pkg::*;

  logic adv;
  logic accept;

  // stage 1: clamped magnitude
  logic [CMD_BITS:0]   abs_v;
  logic [MAG_BITS-1:0] mag;
  logic                f1_valid_q;
  logic                f1_kind_q;
  logic                f1_neg_q;
  logic [MAG_BITS-1:0] f1_mag_q;

  // stage 2: product with period
  logic [PROD_BITS-1:0] prod;
  logic                 f2_valid_q;
  logic                 f2_kind_q;
  logic                 f2_neg_q;
  logic [PROD_BITS-1:0] f2_prod_q;

  // stage 3: quotient by five
  logic [QIN_BITS-1:0]   qin;
  logic                  frac_nz;
  logic [QPROD_BITS-1:0] qprod;
  logic                  f3_valid_q;
  logic                  f3_kind_q;
  logic                  f3_neg_q;
  logic                  f3_frac_nz_q;
  logic [QIN_BITS-1:0]   f3_x_q;
  logic [QUO_BITS-1:0]   f3_q_q;

  // stage 4: final compare and op code
  logic [QIN_BITS-1:0]    five_q;
  logic                   round_up;
  logic [QUO_BITS-1:0]    ceil_q;
  logic [PERIOD_BITS-1:0] half;
  logic [QUO_BITS-1:0]    pos_a;
  logic [CMP_BITS-1:0]    cmp_v;
  scpg_entry_t            entry_d;
  logic                   f4_valid_q;
  scpg_entry_t            f4_q;

  assign adv        = !(f4_valid_q && q_full_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  assign abs_v = in_item_i.command[CMD_BITS-1]
               ? ((CMD_BITS+1)'(0) - {in_item_i.command[CMD_BITS-1], in_item_i.command})
               : {1'b0, in_item_i.command};
  assign mag   = (abs_v > (CMD_BITS+1)'(CMD_LIMIT)) ? CMD_LIMIT : abs_v[MAG_BITS-1:0];

  assign prod = PROD_BITS'(period_i) * PROD_BITS'(f1_mag_q);

  // dual divides by 10240 = 2048*5, single by 20480 = 4096*5
  assign qin     = dual_i ? f2_prod_q[PROD_BITS-1:11] : {1'b0, f2_prod_q[PROD_BITS-1:12]};
  assign frac_nz = !dual_i && (f2_prod_q[11:0] != 12'd0);
  assign qprod   = QPROD_BITS'(qin) * QPROD_BITS'(RECIP5);

  assign five_q   = {f3_q_q, 2'b00} + QIN_BITS'(f3_q_q);
  assign round_up = f3_frac_nz_q || (five_q != f3_x_q);
  assign ceil_q   = f3_q_q + QUO_BITS'(round_up);
  assign half     = {1'b0, period_i[PERIOD_BITS-1:1]};
  assign pos_a    = f3_q_q + QUO_BITS'(half);

  always_comb begin
    cmp_v = f3_q_q[CMP_BITS-1:0];
    if (!dual_i) begin
      if (!f3_neg_q) begin
        cmp_v = pos_a[CMP_BITS-1:0];
      end else if (ceil_q > QUO_BITS'(half)) begin
        cmp_v = '0; // saturate a negative offset compare
      end else begin
        cmp_v = half - ceil_q[CMP_BITS-1:0];
      end
    end
  end

  always_comb begin
    entry_d.cmp = cmp_v;
    if (f3_kind_q == KIND_TICK) begin
      entry_d.op = OP_TICK;
    end else if (!dual_i) begin
      entry_d.op = OP_SINGLE_A;
    end else if (f3_neg_q) begin
      entry_d.op = OP_DUAL_B;
    end else begin
      entry_d.op = OP_DUAL_A;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
      f3_valid_q <= 1'b0;
      f4_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= accept;
      f2_valid_q <= f1_valid_q;
      f3_valid_q <= f2_valid_q;
      f4_valid_q <= f3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_kind_q    <= in_item_i.kind;
      f1_neg_q     <= in_item_i.command[CMD_BITS-1];
      f1_mag_q     <= mag;
      f2_kind_q    <= f1_kind_q;
      f2_neg_q     <= f1_neg_q;
      f2_prod_q    <= prod;
      f3_kind_q    <= f2_kind_q;
      f3_neg_q     <= f2_neg_q;
      f3_frac_nz_q <= frac_nz;
      f3_x_q       <= qin;
      f3_q_q       <= qprod[QPROD_BITS-1:RECIP_SHIFT];
      f4_q         <= entry_d;
    end
  end

  assign push_o  = f4_valid_q && !q_full_i;
  assign entry_o = f4_q;

  `SCPG_ASSERT(a_front_mag_clamped, f1_valid_q |-> (f1_mag_q <= CMD_LIMIT), "magnitude above limit")
  `SCPG_ASSERT(a_front_no_push_full, push_o |-> !q_full_i, "push into full queue")
  `SCPG_ASSERT(a_front_hold_on_full, (f4_valid_q && q_full_i) |=> f4_valid_q, "entry dropped")

endmodule

### src/scpg_queue.sv
// Short queue of classified operations between front and back ends.
`include "signed_command_pwm_generator_defines.svh"
module scpg_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  scpg_pkg::scpg_entry_t entry_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  logic                  pop_i,
  output scpg_pkg::scpg_entry_t head_o
);
  import scpg_pkg::*;

  scpg_entry_t          slots_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q;
  logic [QPTR_BITS-1:0] rd_ptr_q;
  logic [QCNT_BITS-1:0] cnt_q;
  logic [QCNT_BITS-1:0] cnt_d;

  assign full_o  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  `SCPG_ASSERT(a_queue_bound, cnt_q <= QCNT_BITS'(QUEUE_DEPTH), "queue count overflow")
  `SCPG_ASSERT(a_queue_fill, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1), "count not advanced")
  `SCPG_ASSERT(a_queue_pop_nonempty, pop_i |-> valid_o, "pop from empty queue")

endmodule

### src/scpg_back.sv
// Back end: counter, shadow and active compares, pin levels, output register.
`include "signed_command_pwm_generator_defines.svh"
module scpg_back #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [scpg_pkg::PERIOD_BITS-1:0] period_i,
  input  logic                             dual_i,
  input  logic                             q_valid_i,
  input  scpg_pkg::scpg_entry_t            q_entry_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output scpg_pkg::scpg_out_t              out_item_o
);
  import scpg_pkg::*;

  localparam int unsigned CW = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;

  logic [COUNT_BITS-1:0] counter_q, counter_d, cnt_nx;
  logic [CMP_BITS-1:0]   shadow_a_q, shadow_a_d;
  logic [CMP_BITS-1:0]   shadow_b_q, shadow_b_d;
  logic [CMP_BITS-1:0]   active_a_q, active_a_d;
  logic [CMP_BITS-1:0]   active_b_q, active_b_d;
  logic                  level_a_q, level_a_d;
  logic                  level_b_q, level_b_d;
  logic                  out_valid_q, out_valid_d;
  scpg_out_t             out_q, out_d;
  logic [CW-1:0]         cnt_ext, nx_ext, per_ext;

  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  assign cnt_ext = CW'(counter_q);
  assign per_ext = CW'(period_i);
  // any count at or above period wraps to zero
  assign cnt_nx  = (cnt_ext >= per_ext) ? '0 : counter_q + 1'b1;
  assign nx_ext  = CW'(cnt_nx);

  always_comb begin
    counter_d  = counter_q;
    shadow_a_d = shadow_a_q;
    shadow_b_d = shadow_b_q;
    active_a_d = active_a_q;
    active_b_d = active_b_q;
    level_a_d  = level_a_q;
    level_b_d  = level_b_q;
    if (q_pop_o) begin
      unique case (q_entry_i.op)
        OP_TICK: begin
          counter_d = cnt_nx;
          if (nx_ext == per_ext) begin
            // period event wins over a compare match
            active_a_d = shadow_a_q;
            active_b_d = shadow_b_q;
            level_a_d  = 1'b1;
            level_b_d  = 1'b1;
          end else begin
            if (nx_ext == CW'(active_a_q)) begin
              level_a_d = 1'b0;
            end
            if (nx_ext == CW'(active_b_q)) begin
              level_b_d = 1'b0;
            end
          end
        end
        OP_SINGLE_A: begin
          shadow_a_d = q_entry_i.cmp;
        end
        OP_DUAL_A: begin
          shadow_a_d = q_entry_i.cmp;
          shadow_b_d = '0;
        end
        OP_DUAL_B: begin
          shadow_a_d = '0;
          shadow_b_d = q_entry_i.cmp;
        end
        default: begin
        end
      endcase
      if (!dual_i) begin
        level_b_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d       = q_pop_o || (out_valid_q && out_stall_i);
    out_d.pin_a       = level_a_d;
    out_d.pin_b       = level_b_d;
    out_d.count_now   = CMP_BITS'(CW'(counter_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= '0;
      shadow_a_q  <= '0;
      shadow_b_q  <= '0;
      active_a_q  <= '0;
      active_b_q  <= '0;
      level_a_q   <= 1'b0;
      level_b_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      counter_q   <= counter_d;
      shadow_a_q  <= shadow_a_d;
      shadow_b_q  <= shadow_b_d;
      active_a_q  <= active_a_d;
      active_b_q  <= active_b_d;
      level_a_q   <= level_a_d;
      level_b_q   <= level_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SCPG_ASSERT_RST(a_back_reset_empty, !rst_ni |=> !out_valid_q, "output valid in reset")
  `SCPG_ASSERT(a_back_pop_shows, q_pop_o |=> out_valid_q, "popped entry not shown")
  `SCPG_ASSERT(a_back_cmd_no_count, (q_pop_o && q_entry_i.op != OP_TICK) |=> $stable(counter_q), "command moved counter")

endmodule

### src/signed_command_pwm_generator.sv
// Top level of the signed command PWM generator with its configuration registers.
// Path: an accepted item passes 4 compute stages, one queue slot write, then the
//   back end output register. Throughput: one item per cycle while not stalled;
//   the back end applies one queued operation a cycle unless out_stall_i holds it.
// Reset: counter, compares and pins clear, period 1500, single mode; no clearing pass.
module signed_command_pwm_generator #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  scpg_pkg::scpg_in_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output scpg_pkg::scpg_out_t                out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [scpg_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [scpg_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import scpg_pkg::*;

  logic [PERIOD_BITS-1:0] period_q;
  logic                   dual_q;
  logic                   q_full;
  logic                   push;
  scpg_entry_t            entry;
  logic                   q_valid;
  logic                   q_pop;
  scpg_entry_t            q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      dual_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PERIOD:    period_q <= cfg_data_i[PERIOD_BITS-1:0];
        REG_DUAL_MODE: dual_q   <= cfg_data_i[0];
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  scpg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .period_i   (period_q),
    .dual_i     (dual_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (entry)
  );

  scpg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .head_o  (q_head)
  );

  scpg_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (period_q),
    .dual_i      (dual_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### test/tb_top.sv
// Testbench, signed command PWM generator: directed table, then random ticks, commands, writes.
module tb_top;
  import scpg_pkg::*;

  localparam int     DRAIN_CYCLES = 8;
  localparam int     RANDOM_ITEMS = 2000;
  localparam longint TIMEOUT_TU   = 3_000_000;
  localparam int     SINGLE_DIV   = 20480;
  localparam int     DUAL_DIV     = 10240;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 8'd2;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_KNOWN,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    scpg_in_t                 item;
    scpg_out_t                known;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
  } plan_row_t;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  scpg_in_t                 in_item   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  scpg_out_t                out_item;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  // predictor state
  logic [15:0] cur_period   = PERIOD_RESET;
  logic        cur_dual     = 1'b0;
  logic [15:0] carrier_count = '0;
  logic [15:0] shadow_cmp_a = '0;
  logic [15:0] shadow_cmp_b = '0;
  logic [15:0] live_cmp_a   = '0;
  logic [15:0] live_cmp_b   = '0;
  logic        pin_level_a  = 1'b0;
  logic        pin_level_b  = 1'b0;

  scpg_out_t   expected_levels[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  bit          steady     = 1'b0;

  plan_row_t directed_plan [33] = '{
    '{ROW_KNOWN, '{KIND_TICK, 16'sh0000}, '{1'b0, 1'b0, 16'd1}, REG_PERIOD, 16'd0},
    '{ROW_KNOWN, '{KIND_CMD,  16'sh7FFF}, '{1'b0, 1'b0, 16'd1}, REG_PERIOD, 16'd0},
    '{ROW_CFG,   '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd2},
    '{ROW_KNOWN, '{KIND_TICK, 16'sh0000}, '{1'b1, 1'b0, 16'd2}, REG_PERIOD, 16'd0},
    '{ROW_KNOWN, '{KIND_TICK, 16'sh0000}, '{1'b1, 1'b0, 16'd0}, REG_PERIOD, 16'd0},
    '{ROW_ITEM,  '{KIND_CMD,  16'sh8000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_ITEM,  '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_ITEM,  '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_KNOWN, '{KIND_TICK, 16'sh0000}, '{1'b0, 1'b0, 16'd0}, REG_PERIOD, 16'd0},
    '{ROW_CFG,   '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd1},
    '{ROW_ITEM,  '{KIND_CMD,  16'sh8000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_ITEM,  '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_CFG,   '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_KNOWN, '{KIND_TICK, 16'sh0000}, '{1'b1, 1'b0, 16'd0}, REG_PERIOD, 16'd0},
    '{ROW_ITEM,  '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_CFG,   '{KIND_TICK, 16'sh0000}, '0,                   REG_DUAL_MODE, 16'hFFFF},
    '{ROW_ITEM,  '{KIND_CMD,  16'sh1400}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_ITEM,  '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_ITEM,  '{KIND_CMD,  16'shEC00}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_ITEM,  '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_CFG,   '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'hFFFF},
    '{ROW_ITEM,  '{KIND_CMD,  16'sh7FFF}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_ITEM,  '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_ITEM,  '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_CFG,   '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd1},
    '{ROW_ITEM,  '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_ITEM,  '{KIND_CMD,  16'sh8000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_ITEM,  '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_CFG,   '{KIND_TICK, 16'sh0000}, '0,                   REG_UNUSED, 16'd5},
    '{ROW_ITEM,  '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_CFG,   '{KIND_TICK, 16'sh0000}, '0,                   REG_DUAL_MODE, 16'd0},
    '{ROW_ITEM,  '{KIND_CMD,  16'sh0000}, '0,                   REG_PERIOD, 16'd0},
    '{ROW_ITEM,  '{KIND_TICK, 16'sh0000}, '0,                   REG_PERIOD, 16'd0}
  };

  signed_command_pwm_generator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the PWM state by one item and return the pin levels and counter it leaves.
  function automatic scpg_out_t step_pwm(input scpg_in_t it);
    int        cmd;
    longint    cmp;
    longint    prod;
    scpg_out_t r;
    if (it.kind == KIND_CMD) begin
      cmd = int'($signed(it.command));
      if (cmd > int'(CMD_LIMIT)) cmd = int'(CMD_LIMIT);
      if (cmd < -int'(CMD_LIMIT)) cmd = -int'(CMD_LIMIT);
      if (cur_dual) begin
        cmp = longint'(cur_period) * ((cmd < 0) ? -cmd : cmd) / DUAL_DIV;
        if (cmd >= 0) begin
          shadow_cmp_a = cmp[15:0];
          shadow_cmp_b = '0;
        end else begin
          shadow_cmp_a = '0;
          shadow_cmp_b = cmp[15:0];
        end
      end else begin
        prod = longint'(cur_period) * cmd;
        // floor toward minus infinity
        if (prod >= 0) cmp = prod / SINGLE_DIV;
        else cmp = -((-prod + SINGLE_DIV - 1) / SINGLE_DIV);
        cmp = cmp + longint'(cur_period >> 1);
        if (cmp < 0) cmp = 0;
        shadow_cmp_a = cmp[15:0];
      end
    end else begin
      if (carrier_count >= cur_period) carrier_count = '0;
      else carrier_count = carrier_count + 16'd1;
      if (carrier_count == cur_period) begin
        live_cmp_a  = shadow_cmp_a;
        live_cmp_b  = shadow_cmp_b;
        pin_level_a = 1'b1;
        pin_level_b = 1'b1;
      end else begin
        if (carrier_count == live_cmp_a) pin_level_a = 1'b0;
        if (carrier_count == live_cmp_b) pin_level_b = 1'b0;
      end
    end
    if (!cur_dual) pin_level_b = 1'b0;
    r.pin_a     = pin_level_a;
    r.pin_b     = pin_level_b;
    r.count_now = carrier_count;
    return r;
  endfunction

  function automatic logic [15:0] pick_command();
    int v;
    case ($urandom_range(3))
      0: v = int'($urandom);
      1: begin
        case ($urandom_range(7))
          0:       v = 10240;
          1:       v = 10241;
          2:       v = -10240;
          3:       v = -10241;
          4:       v = 32767;
          5:       v = -32768;
          6:       v = -1;
          default: v = 1;
        endcase
      end
      default: v = int'($urandom_range(20480)) - 10240;
    endcase
    return v[15:0];
  endfunction

  task automatic send_item(input scpg_in_t it, input bit use_known, input scpg_out_t known);
    scpg_out_t levels;
    while (!steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    levels = step_pwm(it);
    expected_levels.push_back(use_known ? known : levels);
    items_sent++;
  endtask

  // Write one register once the block has drained.
  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PERIOD:    cur_period = data;
      REG_DUAL_MODE: cur_dual   = data[0];
      default: ;
    endcase
  endtask

  initial begin
    scpg_in_t    it;
    logic [15:0] new_period;
    int          phase_len;
    int          pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_CFG) begin
        write_register(directed_plan[r].cfg_index, directed_plan[r].cfg_data);
      end else begin
        send_item(directed_plan[r].item, directed_plan[r].kind == ROW_KNOWN,
                  directed_plan[r].known);
      end
    end

    while (items_sent < $size(directed_plan) + RANDOM_ITEMS) begin
      steady = (items_sent >= 1000 && items_sent < 1400);
      pick = $urandom_range(99);
      if (pick < 70) begin
        new_period = 16'($urandom_range(40));
      end else if (pick < 88) begin
        new_period = 16'($urandom_range(3000, 41));
      end else if (pick < 94) begin
        new_period = 16'($urandom);
      end else begin
        case ($urandom_range(2))
          0:       new_period = 16'd0;
          1:       new_period = 16'd1;
          default: new_period = 16'hFFFF;
        endcase
      end
      if ($urandom_range(3) != 0) write_register(REG_PERIOD, new_period);
      if ($urandom_range(1) != 0) write_register(REG_DUAL_MODE, 16'($urandom));
      if ($urandom_range(3) == 0) write_register(8'($urandom_range(255, 2)), 16'($urandom));
      // keep long carriers short so most runs see many period events
      phase_len = (cur_period <= 16'd40) ? $urandom_range(160, 40) : $urandom_range(40, 10);
      repeat (phase_len) begin
        it.kind    = ($urandom_range(99) < 15) ? KIND_CMD : KIND_TICK;
        it.command = pick_command();
        send_item(it, 1'b0, '0);
      end
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(posedge clk) begin
    scpg_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        $display("%0t unexpected transaction: expected none actual a=%0d b=%0d count=%0d",
                 $time, out_item.pin_a, out_item.pin_b, out_item.count_now);
        mismatches++;
      end else begin
        want = expected_levels.pop_front();
        if (out_item.pin_a !== want.pin_a) begin
          $display("%0t bad pin_a: expected %0d actual %0d", $time, want.pin_a, out_item.pin_a);
          mismatches++;
        end
        if (out_item.pin_b !== want.pin_b) begin
          $display("%0t bad pin_b: expected %0d actual %0d", $time, want.pin_b, out_item.pin_b);
          mismatches++;
        end
        if (out_item.count_now !== want.count_now) begin
          $display("%0t bad count_now: expected %0d actual %0d", $time, want.count_now,
                   out_item.count_now);
          mismatches++;
        end
      end
    end
    out_stall <= (!steady && $urandom_range(99) < 29);
  end

  initial begin
    #(TIMEOUT_TU);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/scpg_pkg.sv
src/scpg_front.sv
src/scpg_queue.sv
src/scpg_back.sv
src/signed_command_pwm_generator.sv
test/tb_top.sv
